[design/btc_pkg.sv]
// Shared types and constants for the barometric compensation pipeline.
package btc_pkg;

   localparam int DIV_W     = 32;
   localparam int UP_W      = 19;
   localparam int CSR_IDX_W = 4;
   localparam int LATENCY   = 2 * DIV_W + 11;

   localparam logic [CSR_IDX_W-1:0] REG_AC1     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AC2     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AC3     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AC4     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AC5_AC6 = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_B1_B2   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MC_MD   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OSS     = 4'd7;

   localparam logic [31:0] B6_OFFSET  = 32'd4000;
   localparam logic [31:0] B4_OFFSET  = 32'd32768;
   localparam logic [31:0] B7_SCALE   = 32'd50000;
   localparam logic [31:0] P_COEF_SQ  = 32'd3038;
   localparam logic [31:0] P_COEF_LIN = 32'hFFFF_E343;
   localparam logic [31:0] P_OFFSET   = 32'd3791;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [23:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temperature_decidegrees;
      logic signed [31:0] pressure_pa;
      logic               divide_error;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [31:0] ac5_ac6;
      logic [31:0] b1_b2;
      logic [31:0] mc_md;
      logic [1:0]  oss;
   } cal_type;

   typedef struct packed {
      logic            valid;
      logic [31:0]     b6;
      logic [UP_W-1:0] up;
      logic [15:0]     temp;
      logic            err;
   } mid_in_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] b7;
      logic [31:0] b4;
      logic [15:0] temp;
      logic        err;
   } mid_out_type;

endpackage

[design/btc_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
module btc_div #(
   parameter int PAYLOAD_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [btc_pkg::DIV_W-1:0] in_dividend,
   input  logic [btc_pkg::DIV_W-1:0] in_divisor,
   input  logic [PAYLOAD_W-1:0]      in_payload,
   output logic                      out_valid,
   output logic [btc_pkg::DIV_W-1:0] out_quotient,
   output logic [PAYLOAD_W-1:0]      out_payload
);

   localparam int W = btc_pkg::DIV_W;

   logic [W-1:0]         rem_ff [0:W-1];
   logic [W-1:0]         num_ff [0:W-1];
   logic [W-1:0]         den_ff [0:W-1];
   logic                 val_ff [0:W-1];
   logic [PAYLOAD_W-1:0] pl_ff  [0:W-1];

   logic [W-1:0]         rem_src [0:W-1];
   logic [W-1:0]         num_src [0:W-1];
   logic [W-1:0]         den_src [0:W-1];
   logic                 val_src [0:W-1];
   logic [PAYLOAD_W-1:0] pl_src  [0:W-1];

   for (genvar i = 0; i < W; i++) begin : g_stage
      logic [W:0]   trial;
      logic [W:0]   diff;
      logic         ge;
      logic [W-1:0] rem_in;
      logic [W-1:0] num_in;

      if (i == 0) begin : g_first
         assign rem_src[i] = '0;
         assign num_src[i] = in_dividend;
         assign den_src[i] = in_divisor;
         assign val_src[i] = in_valid;
         assign pl_src[i]  = in_payload;
      end else begin : g_next
         assign rem_src[i] = rem_ff[i-1];
         assign num_src[i] = num_ff[i-1];
         assign den_src[i] = den_ff[i-1];
         assign val_src[i] = val_ff[i-1];
         assign pl_src[i]  = pl_ff[i-1];
      end

      always_comb begin
         trial  = {rem_src[i], num_src[i][W-1]};
         diff   = trial - {1'b0, den_src[i]};
         ge     = (trial >= {1'b0, den_src[i]});
         rem_in = ge ? diff[W-1:0] : trial[W-1:0];
         num_in = {num_src[i][W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i] <= 1'b0;
         end else begin
            val_ff[i] <= val_src[i];
         end
         rem_ff[i] <= rem_in;
         num_ff[i] <= num_in;
         den_ff[i] <= den_src[i];
         pl_ff[i]  <= pl_src[i];
      end
   end

   assign out_valid    = val_ff[W-1];
   assign out_quotient = num_ff[W-1];
   assign out_payload  = pl_ff[W-1];

endmodule

[design/btc_mid.sv]
// Calibration arithmetic from B6 to the B7 dividend and B4 divisor.
module btc_mid (
   input  logic                 clock,
   input  logic                 reset,
   input  btc_pkg::cal_type     cal,
   input  btc_pkg::mid_in_type  mid_in,
   output btc_pkg::mid_out_type mid_out
);

   logic [31:0] ac1, ac2, ac3, ac4, b1, b2;
   assign ac1 = {{16{cal.ac1[15]}}, cal.ac1};
   assign ac2 = {{16{cal.ac2[15]}}, cal.ac2};
   assign ac3 = {{16{cal.ac3[15]}}, cal.ac3};
   assign ac4 = {16'd0, cal.ac4};
   assign b1  = {{16{cal.b1_b2[31]}}, cal.b1_b2[31:16]};
   assign b2  = {{16{cal.b1_b2[15]}}, cal.b1_b2[15:0]};

   // Stage B: square of B6 and the two linear terms.
   logic                     b_valid_ff;
   logic [31:0]              b_sq_ff, b_x2a_ff, b_x1b_ff;
   logic [btc_pkg::UP_W-1:0] b_up_ff;
   logic [15:0]              b_temp_ff;
   logic                     b_err_ff;
   logic [31:0]              b_sq_prod, b_x2a_prod, b_x1b_prod;

   always_comb begin
      b_sq_prod  = mid_in.b6 * mid_in.b6;
      b_x2a_prod = ac2 * mid_in.b6;
      b_x1b_prod = ac3 * mid_in.b6;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= mid_in.valid;
      end
      b_sq_ff   <= 32'($signed(b_sq_prod) >>> 12);
      b_x2a_ff  <= 32'($signed(b_x2a_prod) >>> 11);
      b_x1b_ff  <= 32'($signed(b_x1b_prod) >>> 13);
      b_up_ff   <= mid_in.up;
      b_temp_ff <= mid_in.temp;
      b_err_ff  <= mid_in.err;
   end

   // Stage C: coefficient products on the square term.
   logic                     c_valid_ff;
   logic [31:0]              c_x1a_ff, c_x2a_ff, c_x1b_ff, c_x2b_ff;
   logic [btc_pkg::UP_W-1:0] c_up_ff;
   logic [15:0]              c_temp_ff;
   logic                     c_err_ff;
   logic [31:0]              c_x1a_prod, c_x2b_prod;

   always_comb begin
      c_x1a_prod = b2 * b_sq_ff;
      c_x2b_prod = b1 * b_sq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_x1a_ff  <= 32'($signed(c_x1a_prod) >>> 11);
      c_x2b_ff  <= 32'($signed(c_x2b_prod) >>> 16);
      c_x2a_ff  <= b_x2a_ff;
      c_x1b_ff  <= b_x1b_ff;
      c_up_ff   <= b_up_ff;
      c_temp_ff <= b_temp_ff;
      c_err_ff  <= b_err_ff;
   end

   // Stage D: B3 and the B4 multiplicand.
   logic                     d_valid_ff;
   logic [31:0]              d_b3_ff, d_t4_ff;
   logic [btc_pkg::UP_W-1:0] d_up_ff;
   logic [15:0]              d_temp_ff;
   logic                     d_err_ff;
   logic [31:0]              d_x3, d_b3_pre, d_x3b;

   always_comb begin
      d_x3     = c_x1a_ff + c_x2a_ff;
      d_b3_pre = (((ac1 << 2) + d_x3) << cal.oss) + 32'd2;
      d_x3b    = 32'($signed(c_x1b_ff + c_x2b_ff + 32'd2) >>> 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
      d_b3_ff   <= 32'($signed(d_b3_pre) >>> 2);
      d_t4_ff   <= d_x3b + btc_pkg::B4_OFFSET;
      d_up_ff   <= c_up_ff;
      d_temp_ff <= c_temp_ff;
      d_err_ff  <= c_err_ff;
   end

   // Stage E: B4 and the unscaled B7 difference.
   logic        e_valid_ff;
   logic [31:0] e_b4_ff, e_b7p_ff;
   logic [15:0] e_temp_ff;
   logic        e_err_ff;
   logic [31:0] e_b4_prod;

   assign e_b4_prod = ac4 * d_t4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d_valid_ff;
      end
      e_b4_ff   <= e_b4_prod >> 15;
      e_b7p_ff  <= {{(32 - btc_pkg::UP_W){1'b0}}, d_up_ff} - d_b3_ff;
      e_temp_ff <= d_temp_ff;
      e_err_ff  <= d_err_ff;
   end

   // Stage F: B7 scaled by the oversampling setting, and a zero B4 flagged as an error.
   logic        f_valid_ff;
   logic [31:0] f_b7_ff, f_b4_ff;
   logic [15:0] f_temp_ff;
   logic        f_err_ff;
   logic [31:0] f_b7_prod;

   assign f_b7_prod = e_b7p_ff * (btc_pkg::B7_SCALE >> cal.oss);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
      f_b7_ff   <= f_b7_prod;
      f_b4_ff   <= e_b4_ff;
      f_temp_ff <= e_temp_ff;
      f_err_ff  <= e_err_ff | (e_b4_ff == 32'd0);
   end

   assign mid_out.valid = f_valid_ff;
   assign mid_out.b7    = f_b7_ff;
   assign mid_out.b4    = f_b4_ff;
   assign mid_out.temp  = f_temp_ff;
   assign mid_out.err   = f_err_ff;

endmodule

[design/barometer_pressure_temperature_comp_top.sv]
// Top level of the barometric pressure and temperature compensation pipeline.
//
//  channel   ports                        handshake
//  request   start, busy, req_payload     taken when start is high and busy low
//  result    rsp_valid, rsp_payload       one-cycle strobe, cannot be held off
//  csr       csr_valid/ready/index/data   write when valid and ready are high
//
// A request can be taken in every cycle outside reset; each result goes through
// the two 32-stage divider pipelines (B5 and pressure) plus 11 stages of
// multiply and add. Reset is synchronous and flushes all requests in flight;
// busy is high only during reset. There is no stall path: csr_ready stays high.
module barometer_pressure_temperature_comp_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  btc_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   output btc_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [btc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_data
);

   localparam int UP_W   = btc_pkg::UP_W;
   localparam int DIV1_W = 32 + UP_W + 2;
   localparam int DIV2_W = 16 + 2;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   // Calibration registers.
   btc_pkg::cal_type cal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.ac1     <= 16'd408;
         cal_ff.ac2     <= 16'hFFB8;
         cal_ff.ac3     <= 16'hC7D1;
         cal_ff.ac4     <= 16'd32741;
         cal_ff.ac5_ac6 <= 32'd2146785905;
         cal_ff.b1_b2   <= 32'd405667844;
         cal_ff.mc_md   <= 32'd3724086068;
         cal_ff.oss     <= 2'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            btc_pkg::REG_AC1:     cal_ff.ac1     <= csr_data[15:0];
            btc_pkg::REG_AC2:     cal_ff.ac2     <= csr_data[15:0];
            btc_pkg::REG_AC3:     cal_ff.ac3     <= csr_data[15:0];
            btc_pkg::REG_AC4:     cal_ff.ac4     <= csr_data[15:0];
            btc_pkg::REG_AC5_AC6: cal_ff.ac5_ac6 <= csr_data;
            btc_pkg::REG_B1_B2:   cal_ff.b1_b2   <= csr_data;
            btc_pkg::REG_MC_MD:   cal_ff.mc_md   <= csr_data;
            btc_pkg::REG_OSS:     cal_ff.oss     <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   logic [31:0] ac5, ac6, mc, md;
   assign ac5 = {16'd0, cal_ff.ac5_ac6[31:16]};
   assign ac6 = {16'd0, cal_ff.ac5_ac6[15:0]};
   assign mc  = {{16{cal_ff.mc_md[31]}}, cal_ff.mc_md[31:16]};
   assign md  = {{16{cal_ff.mc_md[15]}}, cal_ff.mc_md[15:0]};

   // Stage 1: X1 from the raw temperature, and UP.
   logic            s1_valid_ff;
   logic [31:0]     s1_x1_ff;
   logic [UP_W-1:0] s1_up_ff;
   logic [31:0]     s1_prod;
   logic [23:0]     s1_up_full;

   always_comb begin
      s1_prod    = ({16'd0, req_payload.raw_temperature} - ac6) * ac5;
      s1_up_full = req_payload.raw_pressure >> (4'd8 - {2'd0, cal_ff.oss});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_x1_ff <= 32'($signed(s1_prod) >>> 15);
      s1_up_ff <= s1_up_full[UP_W-1:0];
   end

   // Stage 2: signed operands turned into magnitudes for the divider.
   logic            s2_valid_ff;
   logic [31:0]     s2_num_ff, s2_den_ff, s2_x1_ff;
   logic [UP_W-1:0] s2_up_ff;
   logic            s2_zero_ff, s2_neg_ff;
   logic [31:0]     s2_den, s2_num;

   always_comb begin
      s2_den = s1_x1_ff + md;
      s2_num = mc << 11;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_num_ff  <= s2_num[31] ? 32'd0 - s2_num : s2_num;
      s2_den_ff  <= s2_den[31] ? 32'd0 - s2_den : s2_den;
      s2_neg_ff  <= s2_num[31] ^ s2_den[31];
      s2_zero_ff <= (s2_den == 32'd0);
      s2_x1_ff   <= s1_x1_ff;
      s2_up_ff   <= s1_up_ff;
   end

   logic              d1_valid;
   logic [31:0]       d1_q;
   logic [DIV1_W-1:0] d1_pl;

   btc_div #(.PAYLOAD_W(DIV1_W)) u_div_temp (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s2_valid_ff),
      .in_dividend  (s2_num_ff),
      .in_divisor   (s2_den_ff),
      .in_payload   ({s2_x1_ff, s2_up_ff, s2_zero_ff, s2_neg_ff}),
      .out_valid    (d1_valid),
      .out_quotient (d1_q),
      .out_payload  (d1_pl)
   );

   // Stage A: B5, saturated temperature and B6.
   logic [31:0] a_x1, a_x2, a_b5, a_t;
   logic [15:0] a_temp;
   btc_pkg::mid_in_type a_ff;

   always_comb begin
      a_x1 = d1_pl[DIV1_W-1 -: 32];
      a_x2 = d1_pl[0] ? 32'd0 - d1_q : d1_q;
      a_b5 = a_x1 + a_x2;
      a_t  = 32'($signed(a_b5 + 32'd8) >>> 4);
      if ($signed(a_t) > 32'sd32767) begin
         a_temp = 16'h7FFF;
      end else if ($signed(a_t) < -32'sd32768) begin
         a_temp = 16'h8000;
      end else begin
         a_temp = a_t[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else begin
         a_ff.valid <= d1_valid;
      end
      a_ff.b6   <= a_b5 - btc_pkg::B6_OFFSET;
      a_ff.up   <= d1_pl[UP_W+1:2];
      a_ff.temp <= a_temp;
      a_ff.err  <= d1_pl[1];
   end

   btc_pkg::mid_out_type mid;

   btc_mid u_mid (
      .clock   (clock),
      .reset   (reset),
      .cal     (cal_ff),
      .mid_in  (a_ff),
      .mid_out (mid)
   );

   // B7 below 2^31 is doubled before the divide, otherwise the quotient is.
   logic              d2_valid;
   logic [31:0]       d2_q;
   logic [DIV2_W-1:0] d2_pl;

   btc_div #(.PAYLOAD_W(DIV2_W)) u_div_pres (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mid.valid),
      .in_dividend  (mid.b7[31] ? mid.b7 : mid.b7 << 1),
      .in_divisor   (mid.b4),
      .in_payload   ({mid.temp, mid.err, mid.b7[31]}),
      .out_valid    (d2_valid),
      .out_quotient (d2_q),
      .out_payload  (d2_pl)
   );

   // Stage H: pressure before the final correction.
   logic        h_valid_ff;
   logic [31:0] h_p_ff, h_sq_ff, h_x2_ff;
   logic [15:0] h_temp_ff;
   logic        h_err_ff;
   logic [31:0] h_p, h_x1, h_lin;

   always_comb begin
      h_p   = d2_pl[0] ? d2_q << 1 : d2_q;
      h_x1  = 32'($signed(h_p) >>> 8);
      h_lin = btc_pkg::P_COEF_LIN * h_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= d2_valid;
      end
      h_p_ff    <= h_p;
      h_sq_ff   <= h_x1 * h_x1;
      h_x2_ff   <= 32'($signed(h_lin) >>> 16);
      h_temp_ff <= d2_pl[DIV2_W-1 -: 16];
      h_err_ff  <= d2_pl[1];
   end

   // Stage I: square term of the correction.
   logic        i_valid_ff;
   logic [31:0] i_p_ff, i_x1_ff, i_x2_ff;
   logic [15:0] i_temp_ff;
   logic        i_err_ff;
   logic [31:0] i_prod;

   assign i_prod = h_sq_ff * btc_pkg::P_COEF_SQ;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else begin
         i_valid_ff <= h_valid_ff;
      end
      i_x1_ff   <= 32'($signed(i_prod) >>> 16);
      i_p_ff    <= h_p_ff;
      i_x2_ff   <= h_x2_ff;
      i_temp_ff <= h_temp_ff;
      i_err_ff  <= h_err_ff;
   end

   // Stage J: final pressure and the output register.
   logic             rsp_valid_ff;
   btc_pkg::rsp_type rsp_ff;
   logic [31:0]      j_corr;

   assign j_corr = 32'($signed(i_x1_ff + i_x2_ff + btc_pkg::P_OFFSET) >>> 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= i_valid_ff;
      end
      rsp_ff.divide_error            <= i_err_ff;
      rsp_ff.temperature_decidegrees <= i_err_ff ? 16'sd0 : $signed(i_temp_ff);
      rsp_ff.pressure_pa             <= i_err_ff ? 32'sd0 : $signed(i_p_ff + j_corr);
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[design/btc_checker.sv]
// Port-level checker for the compensation pipeline, with its bind.
module btc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input btc_pkg::rsp_type rsp_payload,
   input logic             csr_ready
);

   // A result appears only a fixed latency after an accepted request.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, btc_pkg::LATENCY))
      else $error("result without a matching request");

   // A divide error forces both results to zero.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.divide_error) |->
         (rsp_payload.pressure_pa == 32'sd0 &&
          rsp_payload.temperature_decidegrees == 16'sd0))
      else $error("divide error with nonzero results");

   // Reset flushes the pipeline.
   a_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

   // Requests are taken whenever reset is released.
   a_ready: assert property (@(posedge clock)
      !reset |-> (!busy && csr_ready))
      else $error("block refused a request or write outside reset");

endmodule

bind barometer_pressure_temperature_comp_top btc_checker u_btc_checker (.*);
